// ===== hw/rtl/sobel_pkg.sv =====
package sobel_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int SLOT_W    = 2;
    localparam int ADDR_W    = COL_W + SLOT_W;
    localparam int PIX_W     = 24;
    localparam int WID_W     = 11;
    localparam int HGT_W     = 16;
    localparam int GRAD_W    = 12;
    localparam int SUM_W     = 22;
    localparam int MAG_W     = 8;
    localparam int NCH       = 3;

    localparam logic [2:0] ADDR_WIDTH_REG  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT_REG = 3'd4;

    typedef logic signed [GRAD_W-1:0] t_grad;
    typedef logic [MAG_W-1:0]         t_mag;

    // one sobel kernel term: direction x uses columns for sign, y uses rows
    function automatic t_grad kern_term(input logic [1:0] dr, input logic [1:0] dc,
                                        input logic [7:0] v, input logic ydir);
        logic [1:0] a;
        logic [1:0] b;
        t_grad      vs;
        t_grad      t;
        a  = ydir ? dr : dc;
        b  = ydir ? dc : dr;
        vs = t_grad'({4'b0, v});
        t  = (b == 2'd1) ? (vs <<< 1) : vs;
        if (a == 2'd1) begin
            return '0;
        end
        return (a == 2'd0) ? -t : t;
    endfunction

endpackage

// ===== hw/rtl/sobel_line_mem.sv =====
module sobel_line_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [sobel_pkg::ADDR_W-1:0] i_waddr,
    input  logic [sobel_pkg::PIX_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [sobel_pkg::ADDR_W-1:0] i_raddr,
    output logic [sobel_pkg::PIX_W-1:0]  o_rdata
);
    import sobel_pkg::*;

    logic [PIX_W-1:0] r_mem [2**ADDR_W];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/sobel_mag.sv =====
module sobel_mag (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  sobel_pkg::t_grad    i_sx [3],
    input  sobel_pkg::t_grad    i_sy [3],
    output sobel_pkg::t_mag     o_mag [3],
    output logic                o_done
);
    import sobel_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_SQ   = 3'b010,
        M_ROOT = 3'b100
    } t_mstate;

    t_mstate             r_state;
    logic [2:0]          r_k;
    logic [2:0]          r_bit;
    logic                r_done;
    logic [SUM_W-1:0]    r_s [NCH];
    t_mag                r_r [NCH];
    t_grad               op;
    logic signed [2*GRAD_W-1:0] sq;
    logic [1:0]          ch;

    assign ch = r_k[2:1];
    assign op = r_k[0] ? i_sy[ch] : i_sx[ch];
    assign sq = op * op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_k     <= '0;
            r_bit   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_k     <= '0;
                        r_state <= M_SQ;
                        for (int i = 0; i < NCH; i++) begin
                            r_s[i] <= '0;
                            r_r[i] <= '0;
                        end
                    end
                end
                M_SQ: begin
                    r_s[ch] <= r_s[ch] + sq[SUM_W-1:0];
                    if (r_k == 3'd5) begin
                        r_bit   <= 3'd7;
                        r_state <= M_ROOT;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                M_ROOT: begin
                    for (int i = 0; i < NCH; i++) begin
                        logic [7:0]  t;
                        logic [15:0] p;
                        t = r_r[i] | (8'd1 << r_bit);
                        p = t * (t - 8'd1);
                        if ({6'b0, p} < r_s[i]) begin
                            r_r[i] <= t;
                        end
                    end
                    if (r_bit == 3'd0) begin
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end else begin
                        r_bit <= r_bit - 3'd1;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_mag  = r_r;
    assign o_done = r_done;
endmodule

// ===== hw/rtl/sobel_edge_magnitude_rgb_unit.sv =====
// a word that releases a result runs S_START, S_READ, S_DRAIN, S_MAGGO, S_MAGWAIT, S_OUT;
// words without a result are taken back to back, a word with one keeps the input busy
// through nine reads on the line memory's one read port, six shared squarings and 8 root steps
// reset: synchronous active low; clears positions, counters and handshakes,
// registers return to width 640 and height 480; line memory content is not cleared
module sobel_edge_magnitude_rgb_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // red_in, green_in, blue_in
    input  logic        i_s_axis_tuser,  // action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // red_out, green_out, blue_out
    output logic        o_m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sobel_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_START   = 7'b0000010,
        S_READ    = 7'b0000100,
        S_DRAIN   = 7'b0001000,
        S_MAGGO   = 7'b0010000,
        S_MAGWAIT = 7'b0100000,
        S_OUT     = 7'b1000000
    } t_state;

    t_state             r_state;
    logic [WID_W-1:0]   r_width;
    logic [HGT_W-1:0]   r_height;
    logic [WID_W-1:0]   w_eff;
    logic [HGT_W-1:0]   h_eff;

    logic [COL_W-1:0]   r_in_col;
    logic [SLOT_W-1:0]  r_in_slot;
    logic [COL_W-1:0]   r_out_col;
    logic [HGT_W-1:0]   r_out_row;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [HGT_W-1:0]   r_pending;

    logic [COL_W-1:0]   r_c_col;
    logic [HGT_W-1:0]   r_c_row;
    logic [SLOT_W-1:0]  r_c_slot;
    logic               r_c_last;

    logic [1:0]         r_dr, r_dc;
    logic [1:0]         r_tap_dr, r_tap_dc;
    logic               r_tap_vld;
    t_grad              r_sx [NCH];
    t_grad              r_sy [NCH];

    logic               r_ovalid;
    logic [23:0]        r_odata;
    logic               r_olast;

    logic               s_acc;
    logic               cfg_wr;
    logic [WID_W-1:0]   n_in_col;
    logic [HGT_W-1:0]   n_pending;
    logic [WID_W-1:0]   n_out_col;
    logic [HGT_W:0]     n_out_row;
    logic signed [HGT_W+1:0] row_i;
    logic signed [COL_W+1:0] col_i;
    logic               tap_ok;
    logic [ADDR_W-1:0]  raddr;
    logic [PIX_W-1:0]   rdata;
    logic               mag_start;
    logic               mag_done;
    t_mag               mag [NCH];
    logic               out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {16'b0, r_height} : {21'b0, r_width};

    always_comb begin
        w_eff = r_width;
        if (r_width == '0) begin
            w_eff = WID_W'(1);
        end else if (r_width > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        h_eff = (r_height == '0) ? HGT_W'(1) : r_height;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign n_in_col  = {1'b0, r_in_col} + WID_W'(1);
    assign n_pending = (r_pending != 16'hFFFF) ? r_pending + HGT_W'(1) : r_pending;
    assign n_out_col = {1'b0, r_out_col} + WID_W'(1);
    assign n_out_row = {1'b0, r_out_row} + (HGT_W+1)'(1);

    assign row_i  = $signed({2'b0, r_c_row}) + $signed({16'b0, r_dr}) - 18'sd1;
    assign col_i  = $signed({2'b0, r_c_col}) + $signed({10'b0, r_dc}) - 12'sd1;
    assign tap_ok = !row_i[HGT_W+1] && (row_i[HGT_W:0] < {1'b0, h_eff})
                 && !col_i[COL_W+1] && (col_i[COL_W:0] < w_eff);
    assign raddr  = {r_c_slot + SLOT_W'(r_dr) + SLOT_W'(3), col_i[COL_W-1:0]};

    assign mag_start = (r_state == S_MAGGO);
    assign out_free  = !r_ovalid || i_m_axis_tready;

    sobel_line_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (s_acc && !i_s_axis_tuser),
        .i_waddr ({r_in_slot, r_in_col}),
        .i_wdata (i_s_axis_tdata),
        .i_re    (r_state == S_READ),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sobel_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mag_start),
        .i_sx    (r_sx),
        .i_sy    (r_sy),
        .o_mag   (mag),
        .o_done  (mag_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WID_W'(640);
            r_height   <= HGT_W'(480);
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_height <= pwdata[HGT_W-1:0];
            end else begin
                r_width  <= pwdata[WID_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_pending  <= '0;
            r_tap_vld  <= 1'b0;
            r_ovalid   <= 1'b0;
            r_dr       <= '0;
            r_dc       <= '0;
        end else begin
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            r_tap_vld <= 1'b0;
            if (r_tap_vld) begin
                for (int i = 0; i < NCH; i++) begin
                    r_sx[i] <= r_sx[i] + kern_term(r_tap_dr, r_tap_dc, rdata[8*i +: 8], 1'b0);
                    r_sy[i] <= r_sy[i] + kern_term(r_tap_dr, r_tap_dc, rdata[8*i +: 8], 1'b1);
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (i_s_axis_tuser) begin
                            if (r_pending != '0) begin
                                r_state <= S_START;
                            end
                        end else begin
                            if (n_in_col >= w_eff) begin
                                r_in_col  <= '0;
                                r_in_slot <= r_in_slot + SLOT_W'(1);
                            end else begin
                                r_in_col  <= n_in_col[COL_W-1:0];
                            end
                            r_pending <= n_pending;
                            if ({1'b0, n_pending} > {6'b0, w_eff} + 17'd1) begin
                                r_state <= S_START;
                            end
                        end
                    end
                end
                S_START: begin
                    r_c_col  <= r_out_col;
                    r_c_row  <= r_out_row;
                    r_c_slot <= r_out_slot;
                    r_c_last <= (r_out_row == h_eff - HGT_W'(1))
                             && ({1'b0, r_out_col} == w_eff - WID_W'(1));
                    if (n_out_col >= w_eff) begin
                        r_out_col  <= '0;
                        r_out_slot <= r_out_slot + SLOT_W'(1);
                        r_out_row  <= (n_out_row >= {1'b0, h_eff}) ? '0
                                                                   : n_out_row[HGT_W-1:0];
                    end else begin
                        r_out_col <= n_out_col[COL_W-1:0];
                    end
                    if (r_pending != '0) begin
                        r_pending <= r_pending - HGT_W'(1);
                    end
                    for (int i = 0; i < NCH; i++) begin
                        r_sx[i] <= '0;
                        r_sy[i] <= '0;
                    end
                    r_dr    <= '0;
                    r_dc    <= '0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_tap_vld <= tap_ok;
                    r_tap_dr  <= r_dr;
                    r_tap_dc  <= r_dc;
                    if (r_dc == 2'd2) begin
                        r_dc <= '0;
                        if (r_dr == 2'd2) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_dr <= r_dr + 2'd1;
                        end
                    end else begin
                        r_dc <= r_dc + 2'd1;
                    end
                end
                S_DRAIN: r_state <= S_MAGGO;
                S_MAGGO: r_state <= S_MAGWAIT;
                S_MAGWAIT: begin
                    if (mag_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {mag[2], mag[1], mag[0]};
                        r_olast  <= r_c_last;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;
endmodule

// ===== hw/rtl/sobel_checker.sv =====
module sobel_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        pready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output word changed while stalled");

    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared without a busy phase");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("handshakes not idle after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");
endmodule

bind sobel_edge_magnitude_rgb_unit sobel_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .pready          (pready)
);
